>>> design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared constants for the vector normalizer
// Field widths, internal datapath widths and pipeline depth.
// ----------------------------------------------------------------------------
package vn_pkg;
	localparam int IN_WIDTH = 32;
	localparam int OUT_W    = 32;
	localparam int Q_BITS   = 31;                      // magnitude bits of Q1.30 result
	localparam int SQ_W     = 2 * IN_WIDTH;            // one component squared
	localparam int SUM_W    = SQ_W + 2;                // sum of three squares
	localparam int SHIFT_A  = 2 * (Q_BITS - 1) + 2;    // a^2 scaled by 2^62
	localparam int R_W      = SQ_W + SHIFT_A + 4;      // signed remainder
	localparam int P_W      = SUM_W + IN_WIDTH + 2;    // signed d*S
	localparam int LANE_LAT = Q_BITS + 1;
endpackage

>>> design/vn_in_if.sv
// ----------------------------------------------------------------------------
// vn_in_if: input vector channel
// valid/ready handshake carrying one vector item.
// ----------------------------------------------------------------------------
interface vn_in_if;
	import vn_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] vec_x;
	logic signed [IN_WIDTH-1:0] vec_y;
	logic signed [IN_WIDTH-1:0] vec_z;
	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

>>> design/vn_out_if.sv
// ----------------------------------------------------------------------------
// vn_out_if: unit vector result channel
// valid/ready handshake carrying one normalized item.
// ----------------------------------------------------------------------------
interface vn_out_if;
	import vn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] unit_x;
	logic signed [OUT_W-1:0] unit_y;
	logic signed [OUT_W-1:0] unit_z;
	logic                    zero_length;
	modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

>>> design/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize: scale a Q16.16 3-vector to unit length in Q1.30
// Pipeline of 36 register stages (3 front, 32 lane, 1 output; the first loads
// at the accepting edge).
// Throughput: one item per cycle while the output register is not held.
// Pipeline stalls as a whole only while the output register is held.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module vector3_normalize (
	input  logic      clk,
	input  logic      arst_n,
	vn_in_if.sink     vec_in,
	vn_out_if.source  unit_out
);
	import vn_pkg::*;

	localparam int DEPTH = 3 + LANE_LAT;   // stages before the output register

	logic en;
	logic v_q [0:DEPTH-1];
	logic out_v_q;

	// Advance everything when the output register is empty or being drained.
	assign en = !out_v_q || unit_out.ready;
	assign vec_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) v_q[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= vec_in.valid;
			for (int i = 1; i < DEPTH; i++) v_q[i] <= v_q[i-1];
			out_v_q <= v_q[DEPTH-1];
		end
	end

	// Stage 1: take magnitudes, signs and the zero-vector flag.
	logic [IN_WIDTH-1:0] mag_s1 [0:2];
	logic [2:0]          neg_s1;
	logic                zero_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1[0] <= vec_in.vec_x[IN_WIDTH-1] ? IN_WIDTH'(-vec_in.vec_x) : vec_in.vec_x;
			mag_s1[1] <= vec_in.vec_y[IN_WIDTH-1] ? IN_WIDTH'(-vec_in.vec_y) : vec_in.vec_y;
			mag_s1[2] <= vec_in.vec_z[IN_WIDTH-1] ? IN_WIDTH'(-vec_in.vec_z) : vec_in.vec_z;
			neg_s1 <= {vec_in.vec_z[IN_WIDTH-1], vec_in.vec_y[IN_WIDTH-1],
				vec_in.vec_x[IN_WIDTH-1]};
			zero_s1 <= (vec_in.vec_x == '0) && (vec_in.vec_y == '0) && (vec_in.vec_z == '0);
		end
	end

	// Stage 2: square each magnitude.
	logic [SQ_W-1:0] sq_s2 [0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s2[i] <= mag_s1[i] * mag_s1[i];
		end
	end

	// Stage 3: sum of squares; hold squares alongside.
	logic [SQ_W-1:0]  sq_s3 [0:2];
	logic [SUM_W-1:0] sum_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= sq_s2;
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	// Sign and zero flag ride alongside the front stages and lanes.
	logic [2:0] neg_d [0:DEPTH-2];
	logic       zero_d [0:DEPTH-2];
	always_ff @(posedge clk) begin
		if (en) begin
			neg_d[0]  <= neg_s1;
			zero_d[0] <= zero_s1;
			for (int i = 1; i < DEPTH - 1; i++) begin
				neg_d[i]  <= neg_d[i-1];
				zero_d[i] <= zero_d[i-1];
			end
		end
	end

	// One lane per component.
	logic [Q_BITS-1:0] q_lane [0:2];
	for (genvar c = 0; c < 3; c++) begin : g_lane
		vn_lane u_lane (
			.clk (clk),
			.en  (en),
			.sq  (sq_s3[c]),
			.sum (sum_s3),
			.q   (q_lane[c])
		);
	end

	// Merge: apply signs, force zeros for a zero vector.
	logic signed [OUT_W-1:0] unit_q [0:2];
	logic                    zero_q;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_d[DEPTH-2])
					unit_q[i] <= '0;
				else if (neg_d[DEPTH-2][i])
					unit_q[i] <= -$signed(OUT_W'(q_lane[i]));
				else
					unit_q[i] <= $signed(OUT_W'(q_lane[i]));
			end
			zero_q <= zero_d[DEPTH-2];
		end
	end

	assign unit_out.valid       = out_v_q;
	assign unit_out.unit_x      = unit_q[0];
	assign unit_out.unit_y      = unit_q[1];
	assign unit_out.unit_z      = unit_q[2];
	assign unit_out.zero_length = zero_q;

	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && zero_q) |-> (unit_q[0] == '0 && unit_q[1] == '0 && unit_q[2] == '0))
		else $error("zero vector gave nonzero components");

	a_nonzero_has_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !zero_q) |-> (unit_q[0] != '0 || unit_q[1] != '0 || unit_q[2] != '0))
		else $error("nonzero vector gave all-zero components");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (unit_q[0] <= $signed(OUT_W'(1) << 30)
			&& unit_q[0] >= -$signed(OUT_W'(1) << 30)))
		else $error("component exceeds unit range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !unit_out.ready) |=> (out_v_q && $stable(unit_q[0])))
		else $error("output lost during stall");
endmodule

>>> design/vn_lane.sv
// ----------------------------------------------------------------------------
// vn_lane: per-component rounded ratio a*2^30/sqrt(S)
// One pipeline stage per result bit after an initial stage; each bit stage does one wide trial subtract/compare.
// ----------------------------------------------------------------------------
module vn_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [vn_pkg::SQ_W-1:0]     sq,
	input  logic [vn_pkg::SUM_W-1:0]    sum,
	output logic [vn_pkg::Q_BITS-1:0]   q
);
	import vn_pkg::*;

	// R = a^2*2^62 - d^2*S, P = d*S, d = 2q-1
	logic signed [R_W-1:0]   r_s [0:Q_BITS];
	logic signed [P_W-1:0]   p_s [0:Q_BITS];
	logic [SUM_W-1:0]        s_s [0:Q_BITS];
	logic [Q_BITS-1:0]       q_s [0:Q_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= $signed({{(R_W-SQ_W-SHIFT_A){1'b0}}, sq, {SHIFT_A{1'b0}}})
				- $signed({{(R_W-SUM_W){1'b0}}, sum});
			p_s[0] <= -$signed({{(P_W-SUM_W){1'b0}}, sum});
			s_s[0] <= sum;
			q_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
		localparam int B = Q_BITS - 1 - k;
		logic signed [R_W-1:0] p_ext;
		logic signed [R_W-1:0] s_ext;
		logic signed [R_W-1:0] trial;

		always_comb begin
			p_ext = {{(R_W-P_W){p_s[k][P_W-1]}}, p_s[k]};
			s_ext = $signed({{(R_W-SUM_W){1'b0}}, s_s[k]});
			trial = r_s[k] - (p_ext <<< (B + 2)) - (s_ext <<< (2 * B + 2));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_s[k+1] <= s_s[k];
				if (!trial[R_W-1]) begin
					r_s[k+1] <= trial;
					p_s[k+1] <= p_s[k] + $signed(P_W'(s_s[k]) << (B + 1));
					q_s[k+1] <= q_s[k] | (Q_BITS'(1) << B);
				end else begin
					r_s[k+1] <= r_s[k];
					p_s[k+1] <= p_s[k];
					q_s[k+1] <= q_s[k];
				end
			end
		end
	end

	assign q = q_s[Q_BITS];
endmodule
